FILE: src/vibration_highpass_impact_detector_macros.svh
// Assertion macros for the vibration high-pass impact detector checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef VIBRATION_HIGHPASS_IMPACT_DETECTOR_MACROS_SVH
`define VIBRATION_HIGHPASS_IMPACT_DETECTOR_MACROS_SVH

// Clocked property, switched off while reset is high.
`define VHID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define VHID_ASSERT_NEXT(lbl, cond, post, msg) \
  `VHID_ASSERT(lbl, (cond) |=> (post), msg)

`endif

FILE: src/vhid_pkg.sv
// Shared constants, codes and types for the vibration high-pass impact detector.
// Used by the axis lanes, the merge stage, the top level and the checker.
package vhid_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FILTER_BITS = 18;
  localparam int AXES        = 3;

  localparam int GAIN_W  = 16;
  localparam int SEL_W   = 2;
  localparam int THR_W   = 18;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 18;
  localparam int MODE_W  = 2;

  // Filter datapath widths
  localparam int DIFF_W = ((FILTER_BITS > SAMPLE_BITS) ? FILTER_BITS : SAMPLE_BITS) + 2;
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;
  localparam int SQ_W   = 2 * FILTER_BITS;
  localparam int ROOT_W = FILTER_BITS;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
  localparam int EXT_W  = (ROOT_W > LEVEL_W) ? ROOT_W : LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Stream packing
  localparam int NOW_LSB    = AXES * SAMPLE_BITS;
  localparam int IN_DATA_W  = ((NOW_LSB + TIME_W + 7) / 8) * 8;
  localparam int EVENT_BIT  = LEVEL_W;
  localparam int ACTIVE_BIT = LEVEL_W + 1;
  localparam int OUT_DATA_W = ((LEVEL_W + 2 + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MEDIUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS       = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd58982;
  localparam logic [SEL_W-1:0]  SEL_RESET     = 2'd1;
  localparam logic [THR_W-1:0]  THR_LOW_RESET = 18'd8192;
  localparam logic [THR_W-1:0]  THR_MED_RESET = 18'd16384;
  localparam logic [THR_W-1:0]  THR_HI_RESET  = 18'd24576;
  localparam logic [TIME_W-1:0] HOLDOFF_RESET = 32'd1000;

  // Threshold select codes
  localparam logic [SEL_W-1:0] SEL_LOW  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_HIGH = 2'd2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd2;

  typedef struct packed {
    logic clr;     // zero filter state and previous sample
    logic load;    // capture the sample and form the difference
    logic commit;  // write back the saturated filter output
  } lane_ctl_t;

endpackage

FILE: src/vhid_axis_lane.sv
// One axis of the high-pass filter: difference, gain multiply, saturate, square.
// Depends on vhid_pkg; sequenced by the top level through lane_ctl_t.
module vhid_axis_lane import vhid_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  logic        [GAIN_W-1:0]      gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic        [SQ_W-1:0]        sq
);

  localparam logic signed [PROD_W-1:0] HP_MAX =
    {{(PROD_W-FILTER_BITS+1){1'b0}}, {(FILTER_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] HP_MIN = ~HP_MAX;

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [FILTER_BITS-1:0] hp;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      shifted;
  logic signed [FILTER_BITS-1:0] hp_sat;
  logic signed [SQ_W-1:0]        sq_full;

  // Floor shift by the gain's fraction bits, then clamp to the filter range
  always_comb begin
    shifted = prod >>> GAIN_W;
    if (shifted > HP_MAX) begin
      hp_sat = HP_MAX[FILTER_BITS-1:0];
    end else if (shifted < HP_MIN) begin
      hp_sat = HP_MIN[FILTER_BITS-1:0];
    end else begin
      hp_sat = shifted[FILTER_BITS-1:0];
    end
  end

  assign sq_full = hp * hp;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      prev <= '0;
      hp   <= '0;
    end else if (ctl.commit) begin
      prev <= x_reg;
      hp   <= hp_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_reg <= sample;
      diff  <= DIFF_W'(hp) + DIFF_W'(sample) - DIFF_W'(prev);
    end
    prod <= $signed({1'b0, gain}) * diff;
    sq   <= SQ_W'($unsigned(sq_full));
  end

endmodule

FILE: src/vhid_merge.sv
// Merge stage: sums the three lane squares and takes a bit-serial square root.
// Depends on vhid_pkg; one root bit per cycle, ROOT_W root bits per start.
module vhid_merge import vhid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   sq [AXES],
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0]       sum;
  logic [SQ_W-1:0]       n;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_W+1:0]     rem_shift;
  logic [ROOT_W+1:0]     trial;
  logic                  ge;
  logic [ROOT_CNT_W-1:0] cnt;

  always_comb begin
    sum = '0;
    for (int a = 0; a < AXES; a++) begin
      sum = sum + sq[a];
    end
  end

  // Bring down the next two bits and try the next root bit
  assign rem_shift = {rem[ROOT_W-1:0], n[SQ_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign ge        = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == ROOT_CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= sum;
      rem  <= '0;
      root <= '0;
      cnt  <= ROOT_CNT_W'(ROOT_W);
    end else if (busy) begin
      n    <= n << 2;
      rem  <= ge ? (rem_shift - trial) : rem_shift;
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - ROOT_CNT_W'(1);
    end
  end

endmodule

FILE: src/vibration_highpass_impact_detector.sv
// Top level of the vibration high-pass impact detector: control, config, thresholds.
// Depends on vhid_pkg, vhid_axis_lane and vhid_merge.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+-------------------------------------
//   s_axis    | s_axis_tvalid / s_axis_tready | tdata: accel x,y,z, now_ms; tuser: mode
//   m_axis    | m_axis_tvalid / m_axis_tready | tdata: vibration_level, impact, active
//   cfg       | cfg_we (no wait, no readback) | cfg_index, cfg_data
//
// A sample taken while enabled passes the filter steps, the bit-serial square
// root in the merge stage (one root bit a cycle), then the level and decide
// states before the input is ready again; enable, disable and ignored items
// go straight to the output state. One item is in flight at a time; the input is
// taken again as soon as its result sits in the output register, so a stalled
// m_axis holds only the following result. rst is synchronous, active high,
// and restores all config registers and clears the meter (disabled).
module vibration_highpass_impact_detector import vhid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: accel_x, accel_y, accel_z, now_ms
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: vibration_level, impact_event, active, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FILT   = 6'b000010,
    S_ROOT   = 6'b000100,
    S_LEVEL  = 6'b001000,
    S_DECIDE = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  // Filter step counter: product lands on step 0, write back on step 1,
  // squares on step 2, root starts on step 3.
  localparam logic [1:0] STEP_COMMIT = 2'd1;
  localparam logic [1:0] STEP_SUM    = 2'd3;

  state_t state;
  logic [1:0] step_cnt;

  // Configuration registers
  logic [GAIN_W-1:0] filter_gain;
  logic [SEL_W-1:0]  threshold_select;
  logic [THR_W-1:0]  threshold_low;
  logic [THR_W-1:0]  threshold_medium;
  logic [THR_W-1:0]  threshold_high;
  logic [TIME_W-1:0] holdoff_ms;

  // Meter state
  logic               enabled;
  logic               exceeded_before;
  logic [LEVEL_W-1:0] level;
  logic [TIME_W-1:0]  last_exceed;
  logic [TIME_W-1:0]  now_reg;
  logic               event_flag;

  logic                accept;
  logic                out_load;
  lane_ctl_t           lane_ctl;
  logic [SQ_W-1:0]     lane_sq [AXES];
  logic                root_start;
  logic                root_busy;
  logic [ROOT_W-1:0]   root;
  logic [EXT_W-1:0]    root_ext;
  logic [LEVEL_W-1:0]  level_new;
  logic [THR_W-1:0]    threshold;
  logic [TIME_W-1:0]   elapsed;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Load the output register once it is empty or being emptied
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Lane sequencing; enable clears the filters at the transaction itself
  assign lane_ctl.clr    = accept && (s_axis_tuser == MODE_ENABLE);
  assign lane_ctl.load   = accept && (s_axis_tuser == MODE_SAMPLE) && enabled;
  assign lane_ctl.commit = (state == S_FILT) && (step_cnt == STEP_COMMIT);
  assign root_start      = (state == S_FILT) && (step_cnt == STEP_SUM);

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    vhid_axis_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .gain   (filter_gain),
      .sample (s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
      .sq     (lane_sq[a])
    );
  end

  vhid_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .sq    (lane_sq),
    .busy  (root_busy),
    .root  (root)
  );

  // Clamp the root to the level range
  assign root_ext  = EXT_W'(root);
  assign level_new = (root_ext > EXT_W'(LEVEL_MAX)) ? LEVEL_MAX : root_ext[LEVEL_W-1:0];

  // Select code three falls back to the medium threshold
  always_comb begin
    case (threshold_select)
      SEL_LOW:  threshold = threshold_low;
      SEL_HIGH: threshold = threshold_high;
      default:  threshold = threshold_medium;
    endcase
  end

  // Wrapping time since the last exceedance
  assign elapsed = now_reg - last_exceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain      <= GAIN_RESET;
      threshold_select <= SEL_RESET;
      threshold_low    <= THR_LOW_RESET;
      threshold_medium <= THR_MED_RESET;
      threshold_high   <= THR_HI_RESET;
      holdoff_ms       <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_GAIN:      filter_gain      <= cfg_data[GAIN_W-1:0];
        REG_THRESHOLD_SELECT: threshold_select <= cfg_data[SEL_W-1:0];
        REG_THRESHOLD_LOW:    threshold_low    <= cfg_data[THR_W-1:0];
        REG_THRESHOLD_MEDIUM: threshold_medium <= cfg_data[THR_W-1:0];
        REG_THRESHOLD_HIGH:   threshold_high   <= cfg_data[THR_W-1:0];
        REG_HOLDOFF_MS:       holdoff_ms       <= cfg_data[TIME_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step_cnt        <= '0;
      enabled         <= 1'b0;
      exceeded_before <= 1'b0;
      level           <= '0;
      last_exceed     <= '0;
      event_flag      <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      // Refill the output register, or drop valid once the result is taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= OUT_DATA_W'({enabled, event_flag, level});
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_reg    <= s_axis_tdata[NOW_LSB +: TIME_W];
            event_flag <= 1'b0;
            step_cnt   <= '0;
            unique case (s_axis_tuser)
              MODE_ENABLE: begin
                // exceeded_before survives a re-enable
                level       <= '0;
                last_exceed <= '0;
                enabled     <= 1'b1;
                state       <= S_OUT;
              end
              MODE_DISABLE: begin
                enabled <= 1'b0;
                state   <= S_OUT;
              end
              MODE_SAMPLE: begin
                state <= enabled ? S_FILT : S_OUT;
              end
              default: begin
                state <= S_OUT;  // unused mode: report state only
              end
            endcase
          end
        end
        S_FILT: begin
          step_cnt <= step_cnt + 2'd1;
          if (step_cnt == STEP_SUM) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!root_busy) begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          level <= level_new;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          // Every exceedance pushes the holdoff window forward
          if (level > threshold) begin
            if (!(elapsed < holdoff_ms && exceeded_before)) begin
              exceeded_before <= 1'b1;
              event_flag      <= 1'b1;
            end
            last_exceed <= now_reg;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/vhid_checker.sv
// Port-level checker for the vibration high-pass impact detector, bound to the top.
// Depends on vhid_pkg and vibration_highpass_impact_detector_macros.svh.
`include "vibration_highpass_impact_detector_macros.svh"

module vhid_checker import vhid_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // One item in flight: ready is low in the cycle after a transaction
  `VHID_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in flight")

  // An impact is only reported while the meter is enabled
  `VHID_ASSERT(a_event_needs_active, m_axis_tvalid && m_axis_tdata[EVENT_BIT] |-> m_axis_tdata[ACTIVE_BIT], "impact reported while disabled")

  // A stalled result stays offered and unchanged
  `VHID_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `VHID_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind vibration_highpass_impact_detector vhid_checker u_checker (.*);
